@@ src/sequential_list_engine_unit_defines.svh @@
// Assertion macros used by the port checker (sle_chk) of the list engine
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sle_pkg.sv @@
// Types, constants and command codes of the sequential list engine
`default_nettype none

package sle_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request kinds
    localparam logic [1:0] REQ_SEARCH = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // index register operations
    localparam logic [2:0] IDX_HOLD   = 3'd0;
    localparam logic [2:0] IDX_ZERO   = 3'd1;
    localparam logic [2:0] IDX_CNT_M1 = 3'd2;
    localparam logic [2:0] IDX_POS    = 3'd3;
    localparam logic [2:0] IDX_INC    = 3'd4;
    localparam logic [2:0] IDX_DEC    = 3'd5;

    // list memory writes
    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_UP      = 3'd1;
    localparam logic [2:0] WR_DOWN    = 3'd2;
    localparam logic [2:0] WR_AT_POS  = 3'd3;
    localparam logic [2:0] WR_AT_CNT  = 3'd4;

    // count operations
    localparam logic [1:0] CNT_HOLD   = 2'd0;
    localparam logic [1:0] CNT_INC    = 2'd1;
    localparam logic [1:0] CNT_DEC    = 2'd2;

    // pending result operations
    localparam logic [2:0] RES_NONE   = 3'd0;
    localparam logic [2:0] RES_OK     = 3'd1;
    localparam logic [2:0] RES_BAD    = 3'd2;
    localparam logic [2:0] RES_FULL   = 3'd3;
    localparam logic [2:0] RES_HIT    = 3'd4;
    localparam logic [2:0] RES_MISS   = 3'd5;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] element_count;
    } rsp_t;

    typedef struct packed {
        logic       load_req;
        logic [2:0] idx_op;
        logic [2:0] wr_op;
        logic [1:0] cnt_op;
        logic [2:0] res_op;
        logic       out_load;
    } sle_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       empty;
        logic       ins_pos_ok;
        logic       full;
        logic       ins_append;
        logic       del_pos_ok;
        logic       del_last;
        logic       match;
        logic       idx_last;
        logic       idx_at_pos;
        logic       out_free;
    } sle_sts_t;

endpackage

`default_nettype wire

@@ src/sle_dpath.sv @@
// Datapath: list memory, element count, walk index and result registers
`default_nettype none

module sle_dpath
    import sle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire sle_cmd_t cmd,
    output sle_sts_t      sts,
    input  wire logic     rsp_ready,
    output logic          rsp_valid,
    output rsp_t          rsp
);

    logic [VAL_W-1:0] mem [CAPACITY];

    req_t             req_reg;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] rd_data_reg;
    logic [1:0]       res_status_reg;
    logic             res_found_reg;
    logic [POS_W-1:0] res_fpos_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [CMP_W-1:0] cnt_ext, pos_ext, idx_ext, cnt_p1, pos_m1, idx_p1, cnt_m1;

    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;

    assign cnt_ext = CMP_W'(cnt_reg);
    assign pos_ext = CMP_W'(req_reg.position);
    assign idx_ext = CMP_W'(idx_reg);
    assign cnt_p1  = cnt_ext + CMP_W'(1);
    assign cnt_m1  = cnt_ext - CMP_W'(1);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign idx_p1  = idx_ext + CMP_W'(1);

    always_comb
    begin
        sts.req_type   = req_reg.req_type;
        sts.empty      = (cnt_ext == '0);
        sts.ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_p1);
        sts.full       = (cnt_ext == CMP_W'(CAPACITY));
        sts.ins_append = (pos_ext == cnt_p1);
        sts.del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
        sts.del_last   = (pos_ext == cnt_ext);
        sts.match      = (rd_data_reg == req_reg.value);
        sts.idx_last   = (idx_p1 == cnt_ext);
        sts.idx_at_pos = (idx_p1 == pos_ext);
        sts.out_free   = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_ZERO:   idx_next = '0;
            IDX_CNT_M1: idx_next = cnt_m1[ADDR_W-1:0];
            IDX_POS:    idx_next = pos_ext[ADDR_W-1:0];
            IDX_INC:    idx_next = idx_reg + ADDR_W'(1);
            IDX_DEC:    idx_next = idx_reg - ADDR_W'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            WR_NONE:   wr_en = 1'b0;
            WR_UP:     wr_addr = idx_reg + ADDR_W'(1);
            WR_DOWN:   wr_addr = idx_reg - ADDR_W'(1);
            WR_AT_POS:
            begin
                wr_addr = pos_m1[ADDR_W-1:0];
                wr_data = req_reg.value;
            end
            WR_AT_CNT:
            begin
                wr_addr = cnt_ext[ADDR_W-1:0];
                wr_data = req_reg.value;
            end
            default:   wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_INC:  cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC:  cnt_next = cnt_reg - CNT_W'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // list memory with one write port and one registered read port: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_req)
            req_reg <= req;
        case (cmd.res_op)
            RES_NONE: ;
            RES_OK:
            begin
                res_status_reg <= ST_OK;
                res_found_reg  <= 1'b0;
                res_fpos_reg   <= '0;
            end
            RES_BAD:
            begin
                res_status_reg <= ST_BAD_POS;
                res_found_reg  <= 1'b0;
                res_fpos_reg   <= '0;
            end
            RES_FULL:
            begin
                res_status_reg <= ST_FULL;
                res_found_reg  <= 1'b0;
                res_fpos_reg   <= '0;
            end
            RES_HIT:
            begin
                res_status_reg <= ST_OK;
                res_found_reg  <= 1'b1;
                res_fpos_reg   <= idx_p1[POS_W-1:0];
            end
            RES_MISS:
            begin
                res_status_reg <= ST_OK;
                res_found_reg  <= 1'b0;
                res_fpos_reg   <= '0;
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            rsp_reg.status         <= res_status_reg;
            rsp_reg.found          <= res_found_reg;
            rsp_reg.found_position <= res_fpos_reg;
            rsp_reg.element_count  <= cnt_ext[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ src/sle_ctrl.sv @@
// Controller: request decode and walk sequencing for the list engine
`default_nettype none

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire sle_sts_t sts,
    output sle_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_SRCH    = 3'd2;
    localparam logic [2:0] S_INS     = 3'd3;
    localparam logic [2:0] S_INS_PUT = 3'd4;
    localparam logic [2:0] S_DEL     = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        cmd.load_req = 1'b0;
        cmd.idx_op   = IDX_HOLD;
        cmd.wr_op    = WR_NONE;
        cmd.cnt_op   = CNT_HOLD;
        cmd.res_op   = RES_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (sts.req_type)
                    REQ_SEARCH:
                    begin
                        if (sts.empty)
                            cmd.res_op = RES_MISS;
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_SRCH;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (!sts.ins_pos_ok)
                            cmd.res_op = RES_BAD;
                        else if (sts.full)
                            cmd.res_op = RES_FULL;
                        else if (sts.ins_append)
                        begin
                            cmd.wr_op  = WR_AT_CNT;
                            cmd.cnt_op = CNT_INC;
                            cmd.res_op = RES_OK;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_CNT_M1;
                            state_next = S_INS;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (!sts.del_pos_ok)
                            cmd.res_op = RES_BAD;
                        else if (sts.del_last)
                        begin
                            cmd.cnt_op = CNT_DEC;
                            cmd.res_op = RES_OK;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_DEL;
                        end
                    end
                    default: cmd.res_op = RES_BAD;
                endcase
            end
            S_SRCH:
            begin
                if (sts.match)
                begin
                    cmd.res_op = RES_HIT;
                    state_next = S_DONE;
                end
                else if (sts.idx_last)
                begin
                    cmd.res_op = RES_MISS;
                    state_next = S_DONE;
                end
                else
                    cmd.idx_op = IDX_INC;
            end
            S_INS:
            begin
                // move entry idx up one slot, walking toward the insert point
                cmd.wr_op = WR_UP;
                if (sts.idx_at_pos)
                    state_next = S_INS_PUT;
                else
                    cmd.idx_op = IDX_DEC;
            end
            S_INS_PUT:
            begin
                cmd.wr_op  = WR_AT_POS;
                cmd.cnt_op = CNT_INC;
                cmd.res_op = RES_OK;
                state_next = S_DONE;
            end
            S_DEL:
            begin
                cmd.wr_op = WR_DOWN;
                if (sts.idx_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.res_op = RES_OK;
                    state_next = S_DONE;
                end
                else
                    cmd.idx_op = IDX_INC;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ src/sequential_list_engine_unit.sv @@
// Top level of the sequential list engine: controller plus datapath
//
// Keeps an ordered list of up to CAPACITY signed 32-bit words and serves
// search, insert-before and delete-at requests, one result per request.
// Channels: req (req_valid/req_ready, req_t) and rsp (rsp_valid/rsp_ready,
// rsp_t); a transfer happens on a clock edge with valid and ready both high.
// The list sits in a single memory with one write and one registered read
// per cycle, so search and shifting walk the list one entry per cycle.
// Requests settled from the count alone (errors, append, delete of the
// last entry, search of an empty list) walk no entries; a search reads
// entries until a match or the last one, an insert moves the entries
// from the end down to the insert point, and a delete moves the entries
// after the deleted one. A new request is taken as soon as the
// previous one has handed its result to the output register.
// The output register holds a result while the receiver stalls; the next
// request is accepted and worked meanwhile and waits only to hand over.
// Reset empties the list (count 0) and clears rsp_valid; no clearing pass.
`default_nettype none

module sequential_list_engine_unit
    import sle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    sle_cmd_t cmd;
    sle_sts_t sts;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sle_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ src/sle_chk.sv @@
// Port checker for the sequential list engine, bound to the top level
`default_nettype none

`include "sequential_list_engine_unit_defines.svh"

module sle_chk
    import sle_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    `SLE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp dropped or changed while stalled")
    `SLE_ASSERT_IMP(a_found_ok, rsp_valid && rsp.found, rsp.status == ST_OK && rsp.found_position != '0 && rsp.found_position <= rsp.element_count, "found result inconsistent")
    `SLE_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp.found, rsp.found_position == '0, "found_position set without a match")
    `SLE_ASSERT_IMP(a_count_cap, rsp_valid, rsp.element_count <= POS_W'(CAPACITY) && rsp.status <= ST_FULL, "result count or status out of range")
    `SLE_ASSERT_NXT(a_one_inflight, req_valid && req_ready, !req_ready, "second request taken while one is in progress")

endmodule

bind sequential_list_engine_unit sle_chk u_sle_chk (.*);

`default_nettype wire
